// ===== rtl/core/wema_pkg.sv =====
// shared types, constants and elaboration-time helpers for the warm-up ema filter
// no dependencies; imported by every module of the core

package wema_pkg;

  localparam int unsigned DEF_WARMUP_DEPTH = 1023;
  localparam int unsigned DEF_SAMPLE_BITS  = 12;

  localparam int unsigned COUNT_BITS   = 10;
  localparam int unsigned WEIGHT_BITS  = 16;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned SETTLE_BITS  = 10;
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = 10'd1023;
  localparam logic [WEIGHT_BITS-1:0] ALPHA_RESET  = 16'd6554;
  localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 10'd29;

  // ln(20) in q28
  localparam logic [63:0] LN20_Q28 = 64'd804160759;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ALPHA  = 1'b0,
    CFG_SETTLE = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REQ_SEED   = 1'b0,
    REQ_FILTER = 1'b1
  } req_e;

  // control carried from the front stage to the blend stage
  typedef struct packed {
    logic seed;     // load sample as the average
    logic settled;  // count reached settle_count, alpha is the weight
  } wema_ctrl_t;

  // restoring long division, used only while building the warm-up table
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // warm-up weight 1 - 0.05^(1/n) in q0.16, via e^(ln20/8n) raised to the 8th
  function automatic logic [WEIGHT_BITS-1:0] warm_weight(input int unsigned n);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] q;
    logic [63:0] w;
    y    = div_u64(LN20_Q28, 64'(n) * 64'd8);
    term = 64'd1 << 28;
    e    = term;
    for (int k = 1; k <= 12; k++) begin
      term = div_u64((term * y) >> 28, 64'(k));
      e    = e + term;
    end
    for (int k = 0; k < 3; k++) begin
      e = (e * e + (64'd1 << 27)) >> 28;
    end
    q = div_u64((64'd1 << 44) + (e >> 1), e);
    w = (q >= 64'd65536) ? 64'd0 : 64'd65536 - q;
    if (w < 64'd1)     w = 64'd1;
    if (w > 64'd65535) w = 64'd65535;
    return w[WEIGHT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/wema_warm_rom.sv =====
// warm-up weight rom, contents built at elaboration, registered read
// depends on wema_pkg (warm_weight)

module wema_warm_rom import wema_pkg::*; #(
  parameter int unsigned DEPTH = DEF_WARMUP_DEPTH + 1,
  parameter int unsigned AW    = $clog2(DEF_WARMUP_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [AW-1:0]          addr_i,
  output logic [WEIGHT_BITS-1:0] data_o
);

  logic [WEIGHT_BITS-1:0] rom_tbl [DEPTH];
  logic [WEIGHT_BITS-1:0] data_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_tbl
    localparam logic [WEIGHT_BITS-1:0] W = (g == 0) ? '0 : warm_weight(g);
    assign rom_tbl[g] = W;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_tbl[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/wema_front.sv =====
// front stage: sample count, min/max marks and weight-table address per item
// depends on wema_pkg

module wema_front import wema_pkg::*; #(
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int unsigned WARMUP_DEPTH = DEF_WARMUP_DEPTH,
  parameter int unsigned ROM_AW       = $clog2(DEF_WARMUP_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   req_type_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   first_of_read_i,
  input  logic [SETTLE_BITS-1:0] settle_count_i,
  output logic [ROM_AW-1:0]      rom_addr_o,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic [SAMPLE_BITS-1:0] minimum_o,
  output logic [SAMPLE_BITS-1:0] maximum_o,
  output logic [SAMPLE_BITS-1:0] spread_o,
  output wema_ctrl_t             ctrl_o
);

  localparam int unsigned CMP_W = (ROM_AW > COUNT_BITS) ? ROM_AW : COUNT_BITS;

  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic [SAMPLE_BITS-1:0] low_q, low_d, high_q, high_d;
  logic [SAMPLE_BITS-1:0] low_base, high_base;
  logic [SAMPLE_BITS-1:0] sample_q, min_q, max_q, spread_q;
  wema_ctrl_t             ctrl_q, ctrl_d;
  logic [CMP_W-1:0]       count_w, depth_w;

  always_comb begin
    // a filter item before any seed acts as a seed
    ctrl_d.seed = (req_e'(req_type_i) == REQ_SEED) || (count_q == '0);
    if (ctrl_d.seed) begin
      count_d = COUNT_BITS'(1);
    end else if (count_q < COUNT_MAX) begin
      count_d = count_q + COUNT_BITS'(1);
    end else begin
      count_d = count_q;
    end
    ctrl_d.settled = (count_d >= settle_count_i);

    low_base  = first_of_read_i ? '1 : low_q;
    high_base = first_of_read_i ? '0 : high_q;
    high_d    = (sample_i > high_base) ? sample_i : high_base;
    low_d     = (sample_i < low_base) ? sample_i : low_base;
  end

  assign count_w    = CMP_W'(count_d);
  assign depth_w    = CMP_W'(WARMUP_DEPTH);
  assign rom_addr_o = ROM_AW'((count_w > depth_w) ? depth_w : count_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      low_q   <= '1;
      high_q  <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sample_q <= sample_i;
      min_q    <= low_d;
      max_q    <= high_d;
      spread_q <= (high_d >= low_d) ? high_d - low_d : '0;
      ctrl_q   <= ctrl_d;
    end
  end

  assign sample_o  = sample_q;
  assign minimum_o = min_q;
  assign maximum_o = max_q;
  assign spread_o  = spread_q;
  assign ctrl_o    = ctrl_q;

endmodule

// ===== rtl/core/wema_blend.sv =====
// blend stage: average state update and the result register
// depends on wema_pkg

module wema_blend import wema_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned AVG_W       = DEF_SAMPLE_BITS + FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  wema_ctrl_t             ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] minimum_i,
  input  logic [SAMPLE_BITS-1:0] maximum_i,
  input  logic [SAMPLE_BITS-1:0] spread_i,
  input  logic [WEIGHT_BITS-1:0] alpha_i,
  input  logic [WEIGHT_BITS-1:0] warm_weight_i,
  output logic [AVG_W-1:0]       filtered_o,
  output logic [SAMPLE_BITS-1:0] minimum_o,
  output logic [SAMPLE_BITS-1:0] maximum_o,
  output logic [SAMPLE_BITS-1:0] spread_o,
  output logic                   settled_o
);

  localparam int unsigned DIFF_W = AVG_W + 1;
  localparam int unsigned PROD_W = DIFF_W + WEIGHT_BITS + 1;

  logic [AVG_W-1:0]         avg_q, avg_d, target;
  logic [WEIGHT_BITS-1:0]   weight;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod, rounded, step;
  logic [AVG_W-1:0]         filt_q;
  logic [SAMPLE_BITS-1:0]   min_q, max_q, spread_q;
  logic                     settled_q;

  // avg + round(w * (target - avg) / 2^16) equals the two-product blend exactly
  always_comb begin
    target  = {sample_i, FRAC_BITS'(0)};
    weight  = ctrl_i.settled ? alpha_i : warm_weight_i;
    diff    = $signed({1'b0, target}) - $signed({1'b0, avg_q});
    prod    = PROD_W'(diff) * $signed({1'b0, weight});
    rounded = prod + PROD_W'(32768);
    step    = rounded >>> FRAC_BITS;
    avg_d   = ctrl_i.seed ? target : avg_q + step[AVG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (load_i) begin
      avg_q <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      filt_q    <= avg_d;
      min_q     <= minimum_i;
      max_q     <= maximum_i;
      spread_q  <= spread_i;
      settled_q <= ctrl_i.settled;
    end
  end

  assign filtered_o = filt_q;
  assign minimum_o  = min_q;
  assign maximum_o  = max_q;
  assign spread_o   = spread_q;
  assign settled_o  = settled_q;

endmodule

// ===== rtl/core/warmup_ema_sensor_filter_core.sv =====
// top level of the warm-up ema sensor filter: stream ports, config registers, pipeline control
// depends on wema_pkg, wema_warm_rom, wema_front, wema_blend
//
// Exponential moving average over converter samples, one result item per input item.
// An item passes the front and then the result register, and one item is taken every
// cycle while the sink takes results: the front stage (count, min/max marks, weight-table
// lookup) and the blend stage (one signed multiply-add into the average register, then the
// result register) each hold one item, and the result register frees as soon as the sink
// takes its item. The sustained rate is set by the average recurrence in the blend stage.
// A seed item (tuser low) loads the sample as the average; a filter item blends it in
// with a weight from the warm-up table while the count is below settle_count, and with
// alpha afterwards. Configuration writes are meant for idle periods only.

module warmup_ema_sensor_filter_core import wema_pkg::*; #(
  parameter int unsigned WARMUP_DEPTH = DEF_WARMUP_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int unsigned S_TDATA_W    = ((SAMPLE_BITS + 1 + 7) / 8) * 8,
  parameter int unsigned M_TDATA_W    = ((4 * SAMPLE_BITS + FRAC_BITS + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [S_TDATA_W-1:0]     s_axis_tdata,   // sample, first_of_read, zero pad
  input  logic                     s_axis_tuser,   // req_type
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [M_TDATA_W-1:0]     m_axis_tdata,   // filtered, minimum, maximum, spread, pad
  output logic                     m_axis_tuser    // settled
);

  localparam int unsigned ROM_DEPTH = WARMUP_DEPTH + 1;
  localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
  localparam int unsigned AVG_W     = SAMPLE_BITS + FRAC_BITS;

  // configuration registers
  logic [WEIGHT_BITS-1:0] alpha_q;
  logic [SETTLE_BITS-1:0] settle_q;

  // handshake and stage occupancy
  logic a_valid_q, a_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, a_move, s_accept;

  // front stage outputs
  logic [ROM_AW-1:0]      rom_addr;
  logic [WEIGHT_BITS-1:0] warm_w;
  logic [SAMPLE_BITS-1:0] a_sample, a_min, a_max, a_spread;
  wema_ctrl_t             a_ctrl;

  // result register contents
  logic [AVG_W-1:0]       r_filtered;
  logic [SAMPLE_BITS-1:0] r_min, r_max, r_spread;
  logic                   r_settled;

  // config writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RESET;
      settle_q <= SETTLE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA:  alpha_q  <= cfg_data_i[WEIGHT_BITS-1:0];
        CFG_SETTLE: settle_q <= cfg_data_i[SETTLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // two-entry pipeline: front register, then result register
  always_comb begin
    out_free      = !out_valid_q || m_axis_tready;
    a_move        = a_valid_q && out_free;
    s_axis_tready = !a_valid_q || a_move;
    s_accept      = s_axis_tvalid && s_axis_tready;

    a_valid_d = a_valid_q;
    if (s_accept) begin
      a_valid_d = 1'b1;
    end else if (a_move) begin
      a_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (a_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // count and marks advance at accept; table read lands alongside the front register
  wema_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WARMUP_DEPTH(WARMUP_DEPTH),
    .ROM_AW      (ROM_AW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (s_accept),
    .req_type_i     (s_axis_tuser),
    .sample_i       (s_axis_tdata[SAMPLE_BITS-1:0]),
    .first_of_read_i(s_axis_tdata[SAMPLE_BITS]),
    .settle_count_i (settle_q),
    .rom_addr_o     (rom_addr),
    .sample_o       (a_sample),
    .minimum_o      (a_min),
    .maximum_o      (a_max),
    .spread_o       (a_spread),
    .ctrl_o         (a_ctrl)
  );

  wema_warm_rom #(
    .DEPTH(ROM_DEPTH),
    .AW   (ROM_AW)
  ) u_warm_rom (
    .clk_i (clk_i),
    .en_i  (s_accept),
    .addr_i(rom_addr),
    .data_o(warm_w)
  );

  // average update happens exactly once per item, when it enters the result register
  wema_blend #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .AVG_W      (AVG_W)
  ) u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (a_move),
    .ctrl_i       (a_ctrl),
    .sample_i     (a_sample),
    .minimum_i    (a_min),
    .maximum_i    (a_max),
    .spread_i     (a_spread),
    .alpha_i      (alpha_q),
    .warm_weight_i(warm_w),
    .filtered_o   (r_filtered),
    .minimum_o    (r_min),
    .maximum_o    (r_max),
    .spread_o     (r_spread),
    .settled_o    (r_settled)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({r_spread, r_max, r_min, r_filtered});
  assign m_axis_tuser  = r_settled;

endmodule

// ===== tb/warmup_ema_sensor_filter_core_tb.sv =====
// testbench for warmup_ema_sensor_filter_core: streams converter samples and checks each result
// item against an in-bench model of the warm-up ema; depends on wema_pkg and the core rtl

module warmup_ema_sensor_filter_core_tb import wema_pkg::*;;

  // ln(20) in q28, seeds the warm-up weight schedule
  localparam logic [63:0] LN20_FIXED = 64'd804160759;
  localparam int unsigned IDLE_PCT   = 32;

  // one expected result item, fields as they leave the core
  typedef struct packed {
    logic [27:0] filtered;
    logic [11:0] minimum;
    logic [11:0] maximum;
    logic [11:0] spread;
    logic        settled;
  } ema_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // sample[11:0], first_of_read[12], zero pad
  logic        s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;   // filtered[27:0], minimum[39:28], maximum[51:40], spread[63:52]
  logic        m_axis_tuser;   // settled

  // model state and its copy of the registers
  logic [15:0] warm_weights [0:1023];
  logic [27:0] avg_q;
  logic [9:0]  sample_total;
  logic [11:0] low_mark;
  logic [11:0] high_mark;
  logic [15:0] alpha_weight;
  logic [9:0]  settle_target;

  ema_result_t pending_results [$];
  ema_result_t got_result;
  ema_result_t want_result;
  int unsigned mismatch_count = 0;
  bit          source_gaps = 1'b1;
  bit          sink_gaps   = 1'b1;

  warmup_ema_sensor_filter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // weight 1 - 0.05^(1/n) in q0.16: e^(ln20/8n) by taylor series, raised to the 8th
  function automatic logic [15:0] warmup_weight(input int unsigned n);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] q;
    logic [63:0] w;
    y    = LN20_FIXED / (64'(n) * 64'd8);
    term = 64'd1 << 28;
    e    = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 28) / 64'(k);
      e    = e + term;
    end
    for (int k = 0; k < 3; k++) begin
      e = (e * e + (64'd1 << 27)) >> 28;
    end
    q = ((64'd1 << 44) + (e >> 1)) / e;
    w = (q >= 64'd65536) ? 64'd0 : 64'd65536 - q;
    if (w < 64'd1)     w = 64'd1;
    if (w > 64'd65535) w = 64'd65535;
    return w[15:0];
  endfunction

  // advances the model by one accepted item and returns the result it must produce
  task automatic blend_sample(input req_e req, input logic [11:0] smp, input logic first,
                              output ema_result_t res);
    logic [63:0] wt;
    logic [63:0] mix;
    // marks are cleared first, then both are checked on their own
    if (first) begin
      low_mark  = 12'hFFF;
      high_mark = 12'h000;
    end
    if (smp > high_mark) high_mark = smp;
    if (smp < low_mark)  low_mark  = smp;
    // a filter item with no history loads the sample just like a seed
    if (req == REQ_SEED || sample_total == 10'd0) begin
      avg_q        = {smp, 16'h0000};
      sample_total = 10'd1;
    end else begin
      if (sample_total != 10'd1023) sample_total = sample_total + 10'd1;
      // warm-up table while the count is short of settle_count, alpha after that
      wt  = (sample_total < settle_target) ? 64'(warm_weights[sample_total])
                                           : 64'(alpha_weight);
      mix = wt * {36'd0, smp, 16'h0000} + (64'd65536 - wt) * 64'(avg_q) + 64'd32768;
      avg_q = mix[43:16];
    end
    res.filtered = avg_q;
    res.minimum  = low_mark;
    res.maximum  = high_mark;
    res.spread   = (high_mark >= low_mark) ? high_mark - low_mark : 12'd0;
    res.settled  = (sample_total >= settle_target);
  endtask

  // presents one item, holds it until taken, then records what it must yield
  task automatic send_sample(input req_e req, input logic [11:0] smp, input logic first);
    ema_result_t res;
    while (source_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, first, smp};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    blend_sample(req, smp, first, res);
    pending_results.push_back(res);
  endtask

  // sender stops until every result item has come, plus the pipeline depth and margin
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // writes both registers back to back; only called while the core is idle
  task automatic load_settings(input logic [15:0] alpha_word, input logic [15:0] settle_word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ALPHA;
    cfg_data_i <= alpha_word;
    @(posedge clk_i);
    alpha_weight = alpha_word;
    cfg_idx_i  <= CFG_SETTLE;
    cfg_data_i <= settle_word;
    @(posedge clk_i);
    // only the low ten bits are the settle count
    settle_target = settle_word[9:0];
    cfg_we_i <= 1'b0;
  endtask

  // runs of items shaped like reads: a cleared first item, then filter items, rare seeds
  task automatic send_reads(input int unsigned n_items, input int unsigned seed_pct);
    int unsigned sent;
    int unsigned run_len;
    req_e        req;
    logic [11:0] smp;
    logic        first;
    sent = 0;
    while (sent < n_items) begin
      run_len = $urandom_range(12, 1);
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        req   = ($urandom_range(99) < seed_pct) ? REQ_SEED : REQ_FILTER;
        // mostly well-formed reads, a few stray clears mid-run or missing at the start
        first = (i == 0) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 4);
        case ($urandom_range(3))
          0:       smp = $urandom_range(1) ? 12'hFFF : 12'h000;
          1:       smp = 12'd1984 + 12'($urandom_range(127));
          default: smp = 12'($urandom);
        endcase
        send_sample(req, smp, first);
        sent++;
      end
    end
  endtask

  // sample extremes, seed and filter, filter with no history, mark clears
  task automatic test_directed_extremes();
    send_sample(REQ_FILTER, 12'hFFF, 1'b0);  // filter before any seed loads directly
    send_sample(REQ_FILTER, 12'h000, 1'b0);
    send_sample(REQ_FILTER, 12'h800, 1'b0);
    send_sample(REQ_SEED,   12'h000, 1'b1);
    repeat (3) send_sample(REQ_FILTER, 12'hFFF, 1'b0);
    send_sample(REQ_SEED,   12'hFFF, 1'b1);
    send_sample(REQ_FILTER, 12'h000, 1'b1);
    send_sample(REQ_FILTER, 12'h001, 1'b0);
    send_sample(REQ_FILTER, 12'hFFE, 1'b0);
    send_sample(REQ_SEED,   12'hAAA, 1'b0);
    send_sample(REQ_SEED,   12'h555, 1'b1);
    send_sample(REQ_FILTER, 12'h555, 1'b1);
    wait_drained();
  endtask

  // warm-up and steady state at the reset settings
  task automatic test_default_weights();
    send_reads(330, 6);
    wait_drained();
  endtask

  // longest warm-up and count saturation: one seed, then filter items past 1023
  // both sides run without idling here
  task automatic test_count_saturation();
    load_settings(16'hFFFF, 16'd1023);
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    send_sample(REQ_SEED, 12'($urandom), 1'b1);
    for (int i = 0; i < 1100; i++) begin
      // pause mid-run until everything is back, the count must carry across
      if (i == 550) wait_drained();
      send_sample(REQ_FILTER, 12'($urandom), ($urandom_range(99) < 3));
    end
    wait_drained();
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
  endtask

  // several random settings, random spare high bits on the settle word
  task automatic test_random_settings();
    for (int p = 0; p < 4; p++) begin
      load_settings(16'($urandom_range(65535, 1)),
                    {6'($urandom), (p == 3) ? 10'($urandom_range(1023, 1))
                                            : 10'($urandom_range(40, 1))});
      send_reads(60, 8);
      wait_drained();
    end
  endtask

  // zero alpha holds the average, zero settle count means always settled
  task automatic test_zero_alpha_zero_settle();
    load_settings(16'h0000, 16'hFC00);
    send_reads(80, 10);
    wait_drained();
  endtask

  // smallest nonzero weight, alpha taking over right after the seed
  task automatic test_min_weight();
    load_settings(16'h0001, 16'h0001);
    send_reads(80, 10);
    wait_drained();
  endtask

  // sink side: random backpressure unless a test asks for a clean stretch
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (!sink_gaps || $urandom_range(99) >= IDLE_PCT);
  end

  // every taken result item is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_result.filtered = m_axis_tdata[27:0];
      got_result.minimum  = m_axis_tdata[39:28];
      got_result.maximum  = m_axis_tdata[51:40];
      got_result.spread   = m_axis_tdata[63:52];
      got_result.settled  = m_axis_tuser;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: filtered %0d", got_result.filtered);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.filtered !== want_result.filtered) begin
          $error("filtered: expected %0d, got %0d", want_result.filtered, got_result.filtered);
          mismatch_count++;
        end
        if (got_result.minimum !== want_result.minimum) begin
          $error("minimum: expected %0d, got %0d", want_result.minimum, got_result.minimum);
          mismatch_count++;
        end
        if (got_result.maximum !== want_result.maximum) begin
          $error("maximum: expected %0d, got %0d", want_result.maximum, got_result.maximum);
          mismatch_count++;
        end
        if (got_result.spread !== want_result.spread) begin
          $error("spread: expected %0d, got %0d", want_result.spread, got_result.spread);
          mismatch_count++;
        end
        if (got_result.settled !== want_result.settled) begin
          $error("settled: expected %0d, got %0d", want_result.settled, got_result.settled);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // known values on every input from the start
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_ALPHA;
    cfg_data_i    <= 16'h0000;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 16'h0000;
    s_axis_tuser  <= REQ_SEED;

    // model at its reset state
    warm_weights[0] = 16'd0;
    for (int n = 1; n <= 1023; n++) warm_weights[n] = warmup_weight(n);
    avg_q         = '0;
    sample_total  = '0;
    low_mark      = 12'hFFF;
    high_mark     = 12'h000;
    alpha_weight  = ALPHA_RESET;
    settle_target = SETTLE_RESET;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_default_weights();
    test_count_saturation();
    test_random_settings();
    test_zero_alpha_zero_settle();
    test_min_weight();

    // all items are in: let the pipeline empty
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[warmup_ema_sensor_filter_core] OK");
    end else begin
      $display("[warmup_ema_sensor_filter_core] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("[warmup_ema_sensor_filter_core] ERROR");
    $finish;
  end

endmodule
